// ----- design/tis_pkg.sv -----
package tis_pkg;

  localparam int ID_W  = 31;
  localparam int SEQ_W = 32;
  localparam int DLY_W = 32;
  localparam int ORD_W = 32;
  localparam int MAX_FIRES = 16;

  typedef logic [2:0] op_t;
  localparam op_t OP_SET    = 3'd0;
  localparam op_t OP_CLEAR  = 3'd1;
  localparam op_t OP_TICK   = 3'd2;
  localparam op_t OP_BEGIN  = 3'd3;
  localparam op_t OP_FINISH = 3'd4;

  typedef logic [2:0] kind_t;
  localparam kind_t K_SET    = 3'd0;
  localparam kind_t K_CLEAR  = 3'd1;
  localparam kind_t K_FIRE   = 3'd2;
  localparam kind_t K_BEGIN  = 3'd3;
  localparam kind_t K_FINISH = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;

  // next id: wraps past the top and never hands out zero
  function automatic logic [ID_W-1:0] id_inc(input logic [ID_W-1:0] x);
    logic [ID_W-1:0] n;
    n = x + 1'b1;
    if (n == '0) n = {{(ID_W-1){1'b0}}, 1'b1};
    return n;
  endfunction

endpackage

// ----- design/timeout_interval_scheduler.sv -----
// Timer table with set, clear, tick, begin-callback and finish-callback
// operations. One operation is a transfer on the in_ channel; its replies
// leave on the out_ channel, out_last marking the final reply of an input.
// in_stall stays high from acceptance until every reply has been taken, so
// one operation is in flight at a time.
// Entry payload lives in one RAM; valid and armed bits are flip-flops.
// Clear, begin and finish scan the table once, one entry per cycle, before
// their decision; each reply is taken once out_stall is low.
// Set repeats the scan for each id candidate already in use (at most
// NUM_TIMERS scans). Tick scans once per fired entry plus one closing scan
// unless the 16-fire cap is reached, firing at most 16 entries. A tick with
// nothing due and an unknown op produce no reply. A full table answers set
// right away, without a scan.
// While out_stall is high the reply holds and the block waits.
// Reset clears all entries, the time count, id, sequence and arm counters.
module timeout_interval_scheduler #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  tis_pkg::op_t                  in_op,
  input  logic signed [31:0]            in_delay_ticks,
  input  logic                          in_repeat_flag,
  input  logic [30:0]                   in_timer_id,
  input  logic [31:0]                   in_sequence_tag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output tis_pkg::kind_t                out_kind,
  output logic [30:0]                   out_result_id,
  output logic [31:0]                   out_result_sequence,
  output tis_pkg::status_t              out_status,
  output logic                          out_is_repeating,
  output logic                          out_last
);
  import tis_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int INT_W = DLY_W - 1;
  localparam int FC_W  = $clog2(MAX_FIRES + 1);
  // RAM word layout
  localparam int O_ID  = 0;
  localparam int O_SEQ = O_ID + ID_W;
  localparam int O_PER = O_SEQ + SEQ_W;
  localparam int O_INT = O_PER + 1;
  localparam int O_ORD = O_INT + INT_W;
  localparam int O_DL  = O_ORD + ORD_W;
  localparam int W     = O_DL + TIME_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_FLUSH, S_EMIT} state_t;

  state_t                 state_r, ret_r;
  logic [NUM_TIMERS-1:0]  valid_r, armed_r;
  logic [TIME_BITS-1:0]   time_r;
  logic [ID_W-1:0]        last_id_r, key_r;
  logic [SEQ_W-1:0]       last_seq_r, tag_r;
  logic [ORD_W-1:0]       arm_r;
  op_t                    op_r;
  logic [INT_W-1:0]       dly_r;
  logic                   rep_r;
  logic [IDX_W-1:0]       slot_r, pa_r, sel_idx_r;
  logic [CNT_W-1:0]       iss_r;
  logic                   rd_pend_r, sel_ok_r, pend_ok_r;
  logic [W-1:0]           sel_word_r;
  logic [ID_W-1:0]        pend_id_r;
  logic [SEQ_W-1:0]       pend_seq_r;
  logic                   pend_per_r;
  logic [FC_W-1:0]        fcnt_r;
  logic                   out_valid_r, out_rep_r, out_last_r;
  kind_t                  out_kind_r;
  logic [ID_W-1:0]        out_id_r;
  logic [SEQ_W-1:0]       out_seq_r;
  status_t                out_status_r;

  // RAM ports
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [W-1:0]     wr_data, rdata;

  tis_ram #(.WIDTH(W), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (iss_r[IDX_W-1:0]),
    .rdata (rdata)
  );

  // lowest free slot
  logic [IDX_W-1:0] free_idx;
  logic             full;
  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) free_idx = IDX_W'(i);
    end
  end
  assign full = &valid_r;

  // entry returning from the RAM
  logic [ID_W-1:0]      rd_id;
  logic [ORD_W-1:0]     rd_ord;
  logic [TIME_BITS-1:0] rd_dl, sel_dl;
  logic [ORD_W-1:0]     sel_ord;
  logic                 ev_valid, ev_match, ev_better;
  assign rd_id   = rdata[O_ID +: ID_W];
  assign rd_ord  = rdata[O_ORD +: ORD_W];
  assign rd_dl   = rdata[O_DL +: TIME_BITS];
  assign sel_dl  = sel_word_r[O_DL +: TIME_BITS];
  assign sel_ord = sel_word_r[O_ORD +: ORD_W];
  assign ev_valid = rd_pend_r && valid_r[pa_r];
  assign ev_match = ev_valid && (rd_id == key_r);
  assign ev_better = ev_valid && armed_r[pa_r] && (rd_dl <= time_r) &&
                     (!sel_ok_r || (rd_dl < sel_dl) ||
                      ((rd_dl == sel_dl) && (rd_ord < sel_ord)));

  assign rd_en = (state_r == S_SCAN) && (iss_r < CNT_W'(NUM_TIMERS));

  // saturating deadlines
  logic [TIME_BITS:0]   set_sum, fin_sum;
  logic [TIME_BITS-1:0] set_dl, fin_dl;
  logic [SEQ_W-1:0]     next_seq;
  logic                 sel_per, chk_ok;
  assign set_sum  = {1'b0, time_r} + {{(TIME_BITS + 1 - INT_W){1'b0}}, dly_r};
  assign set_dl   = set_sum[TIME_BITS] ? TMAX : set_sum[TIME_BITS-1:0];
  assign fin_sum  = {1'b0, sel_dl} +
                    {{(TIME_BITS + 1 - INT_W){1'b0}}, sel_word_r[O_INT +: INT_W]};
  always_comb begin
    fin_dl = fin_sum[TIME_BITS] ? TMAX : fin_sum[TIME_BITS-1:0];
    if (fin_dl < time_r) fin_dl = time_r;
  end
  assign next_seq = last_seq_r + 1'b1;
  assign sel_per  = sel_word_r[O_PER];
  assign chk_ok   = sel_ok_r && (sel_word_r[O_SEQ +: SEQ_W] == tag_r);

  // write-back decisions
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_r;
    wr_data = sel_word_r;
    if (state_r == S_DECIDE) begin
      if (op_r == OP_SET && !sel_ok_r) begin
        wr_en   = 1'b1;
        wr_data = {set_dl, arm_r, dly_r, rep_r, next_seq, key_r};
      end else if (op_r == OP_FINISH && chk_ok && sel_per && !armed_r[sel_idx_r]) begin
        wr_en   = 1'b1;
        wr_addr = sel_idx_r;
        wr_data = {fin_dl, arm_r, sel_word_r[O_ORD-1:0]};
      end
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_result_id       = out_id_r;
  assign out_result_sequence = out_seq_r;
  assign out_status          = out_status_r;
  assign out_is_repeating    = out_rep_r;
  assign out_last            = out_last_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      valid_r     <= '0;
      armed_r     <= '0;
      time_r      <= '0;
      last_id_r   <= '0;
      last_seq_r  <= '0;
      arm_r       <= '0;
      rd_pend_r   <= 1'b0;
      sel_ok_r    <= 1'b0;
      pend_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      iss_r       <= '0;
      fcnt_r      <= '0;
    end else begin
      rd_pend_r <= rd_en;
      pa_r      <= iss_r[IDX_W-1:0];
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_op;
            dly_r     <= in_delay_ticks[31] ? '0 : in_delay_ticks[INT_W-1:0];
            rep_r     <= in_repeat_flag;
            tag_r     <= in_sequence_tag;
            // set searches from the next id, the others look up the given id
            key_r     <= (in_op == OP_SET) ? id_inc(last_id_r) : in_timer_id;
            iss_r     <= '0;
            sel_ok_r  <= 1'b0;
            pend_ok_r <= 1'b0;
            fcnt_r    <= '0;
            case (in_op)
              OP_SET: begin
                if (full) begin
                  out_kind_r   <= K_SET;
                  out_id_r     <= '0;
                  out_seq_r    <= '0;
                  out_status_r <= ST_FULL;
                  out_rep_r    <= 1'b0;
                  out_last_r   <= 1'b1;
                  out_valid_r  <= 1'b1;
                  ret_r        <= S_IDLE;
                  state_r      <= S_EMIT;
                end else begin
                  slot_r  <= free_idx;
                  state_r <= S_SCAN;
                end
              end
              OP_CLEAR, OP_BEGIN, OP_FINISH: state_r <= S_SCAN;
              OP_TICK: begin
                if (time_r != TMAX) time_r <= time_r + 1'b1;
                state_r <= S_SCAN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end

        S_SCAN: begin
          if (rd_en) iss_r <= iss_r + 1'b1;
          if (op_r == OP_TICK ? ev_better : ev_match) begin
            sel_ok_r   <= 1'b1;
            sel_idx_r  <= pa_r;
            sel_word_r <= rdata;
          end
          if (rd_pend_r && pa_r == IDX_W'(NUM_TIMERS - 1)) state_r <= S_DECIDE;
        end

        S_DECIDE: begin
          case (op_r)
            OP_SET: begin
              if (sel_ok_r) begin
                // candidate id in use: try the next one
                key_r    <= id_inc(key_r);
                iss_r    <= '0;
                sel_ok_r <= 1'b0;
                state_r  <= S_SCAN;
              end else begin
                valid_r[slot_r] <= 1'b1;
                armed_r[slot_r] <= 1'b1;
                last_id_r       <= key_r;
                last_seq_r      <= next_seq;
                arm_r           <= arm_r + 1'b1;
                out_kind_r      <= K_SET;
                out_id_r        <= key_r;
                out_seq_r       <= next_seq;
                out_status_r    <= ST_OK;
                out_rep_r       <= rep_r;
                out_last_r      <= 1'b1;
                out_valid_r     <= 1'b1;
                ret_r           <= S_IDLE;
                state_r         <= S_EMIT;
              end
            end
            OP_CLEAR: begin
              out_kind_r   <= K_CLEAR;
              out_id_r     <= key_r;
              out_seq_r    <= sel_ok_r ? sel_word_r[O_SEQ +: SEQ_W] : '0;
              out_status_r <= sel_ok_r ? ST_OK : ST_NOTFOUND;
              out_rep_r    <= sel_ok_r && sel_per;
              out_last_r   <= 1'b1;
              out_valid_r  <= 1'b1;
              if (sel_ok_r) begin
                valid_r[sel_idx_r] <= 1'b0;
                armed_r[sel_idx_r] <= 1'b0;
              end
              ret_r   <= S_IDLE;
              state_r <= S_EMIT;
            end
            OP_BEGIN, OP_FINISH: begin
              out_kind_r   <= (op_r == OP_BEGIN) ? K_BEGIN : K_FINISH;
              out_id_r     <= key_r;
              out_seq_r    <= tag_r;
              out_status_r <= chk_ok ? ST_OK : ST_NOTFOUND;
              out_rep_r    <= chk_ok && sel_per;
              out_last_r   <= 1'b1;
              out_valid_r  <= 1'b1;
              if (op_r == OP_BEGIN && chk_ok && !sel_per) begin
                valid_r[sel_idx_r] <= 1'b0;
                armed_r[sel_idx_r] <= 1'b0;
              end
              if (op_r == OP_FINISH && chk_ok && sel_per && !armed_r[sel_idx_r]) begin
                armed_r[sel_idx_r] <= 1'b1;
                arm_r              <= arm_r + 1'b1;
              end
              ret_r   <= S_IDLE;
              state_r <= S_EMIT;
            end
            OP_TICK: begin
              // a fire is held back one round so its last flag is known
              out_kind_r   <= K_FIRE;
              out_id_r     <= pend_id_r;
              out_seq_r    <= pend_seq_r;
              out_status_r <= ST_OK;
              out_rep_r    <= pend_per_r;
              if (!sel_ok_r) begin
                out_last_r  <= 1'b1;
                out_valid_r <= pend_ok_r;
                pend_ok_r   <= 1'b0;
                ret_r       <= S_IDLE;
                state_r     <= pend_ok_r ? S_EMIT : S_IDLE;
              end else begin
                armed_r[sel_idx_r] <= 1'b0;
                fcnt_r     <= fcnt_r + 1'b1;
                pend_ok_r  <= 1'b1;
                pend_id_r  <= sel_word_r[O_ID +: ID_W];
                pend_seq_r <= sel_word_r[O_SEQ +: SEQ_W];
                pend_per_r <= sel_per;
                out_last_r <= 1'b0;
                out_valid_r <= pend_ok_r;
                iss_r      <= '0;
                sel_ok_r   <= 1'b0;
                if (fcnt_r == FC_W'(MAX_FIRES - 1)) begin
                  ret_r   <= S_FLUSH;
                  state_r <= pend_ok_r ? S_EMIT : S_FLUSH;
                end else begin
                  ret_r   <= S_SCAN;
                  state_r <= pend_ok_r ? S_EMIT : S_SCAN;
                end
              end
            end
            default: state_r <= S_IDLE;
          endcase
        end

        S_FLUSH: begin
          out_kind_r   <= K_FIRE;
          out_id_r     <= pend_id_r;
          out_seq_r    <= pend_seq_r;
          out_status_r <= ST_OK;
          out_rep_r    <= pend_per_r;
          out_last_r   <= 1'b1;
          out_valid_r  <= 1'b1;
          pend_ok_r    <= 1'b0;
          ret_r        <= S_IDLE;
          state_r      <= S_EMIT;
        end

        S_EMIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            iss_r       <= '0;
            sel_ok_r    <= 1'b0;
            state_r     <= ret_r;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/tis_ram.sv -----
module tis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
